// ===== rtl/core/cpv_pkg.sv =====
// Shared types and constants for the cascaded position/velocity PI unit.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package cpv_pkg;

  // Fixed widths of the gain and limit registers and of the write port
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POS_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POS_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL_PROP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL_INTEG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT    = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PP,
    ST_MUL_PI,
    ST_VEL_CMD,
    ST_MUL_VP,
    ST_MUL_VI,
    ST_FINISH
  } state_e;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_POS_PROP,
    MUL_POS_INTEG,
    MUL_VEL_PROP,
    MUL_VEL_INTEG
  } mul_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;      // capture item, form position error
    logic     mul_en;    // advance product and accumulator registers
    mul_sel_e mul_sel;
    logic     cmd_step;  // form velocity command and speed error, step position integral
    logic     out_load;  // form drive value, step velocity integral, fill output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;     // output register holds an item that is not taken this cycle
  } status_t;

endpackage

// ===== rtl/core/cpv_ctrl.sv =====
// Sequencer for the cascaded PI unit: steps one item through the shared multiplier.
// Depends on cpv_pkg.
module cpv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cpv_pkg::status_t status_i,
  output cpv_pkg::cmd_t    cmd_o
);

  cpv_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.mul_en     = 1'b0;
    cmd_o.mul_sel    = cpv_pkg::MUL_POS_PROP;
    cmd_o.cmd_step   = 1'b0;
    cmd_o.out_load   = 1'b0;
    case (state_q)
      cpv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cpv_pkg::ST_MUL_PP;
        end
      end
      cpv_pkg::ST_MUL_PP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpv_pkg::MUL_POS_PROP;
        state_d       = cpv_pkg::ST_MUL_PI;
      end
      cpv_pkg::ST_MUL_PI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpv_pkg::MUL_POS_INTEG;
        state_d       = cpv_pkg::ST_VEL_CMD;
      end
      cpv_pkg::ST_VEL_CMD: begin
        cmd_o.cmd_step = 1'b1;
        state_d        = cpv_pkg::ST_MUL_VP;
      end
      cpv_pkg::ST_MUL_VP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpv_pkg::MUL_VEL_PROP;
        state_d       = cpv_pkg::ST_MUL_VI;
      end
      cpv_pkg::ST_MUL_VI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpv_pkg::MUL_VEL_INTEG;
        state_d       = cpv_pkg::ST_FINISH;
      end
      cpv_pkg::ST_FINISH: begin
        // hold until the output register can take the item
        if (!status_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = cpv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cpv_datapath.sv =====
// Datapath of the cascaded PI unit: gain registers, integrators, shared multiplier,
// saturation and the output register. Depends on cpv_pkg.
module cpv_datapath #(
  parameter int unsigned DATA_WIDTH     = 16,
  parameter int unsigned INTEG_WIDTH    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cpv_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cpv_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic signed [DATA_WIDTH-1:0]        ref_position_i,
  input  logic signed [DATA_WIDTH-1:0]        meas_position_i,
  input  logic signed [DATA_WIDTH-1:0]        meas_speed_i,
  input  cpv_pkg::cmd_t                       cmd_i,
  output cpv_pkg::status_t                    status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [DATA_WIDTH-1:0]        drive_value_o,
  output logic                                drive_saturated_o
);

  localparam int unsigned GW = cpv_pkg::GAIN_W;
  localparam int unsigned LW = cpv_pkg::LIMIT_W;
  localparam int unsigned BW = (DATA_WIDTH > INTEG_WIDTH) ? DATA_WIDTH : INTEG_WIDTH;
  localparam int unsigned PW = GW + BW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned CW = ((INTEG_WIDTH > LW) ? INTEG_WIDTH : LW) + 2;

  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = SW'(DMAX);
  localparam logic signed [SW-1:0] SMIN = SW'(DMIN);
  localparam logic [INTEG_WIDTH-1:0] ITOP = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
  localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;

  // Saturate a widened value to the data range
  function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [SW-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    if (v > SMAX) begin
      r = DMAX;
    end else if (v < SMIN) begin
      r = DMIN;
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic clipped(input logic signed [SW-1:0] v);
    return (v > SMAX) || (v < SMIN);
  endfunction

  // Clamp an integrator sum to [-lim, +lim]
  function automatic logic signed [INTEG_WIDTH-1:0] clamp_integ(
    input logic signed [CW-1:0] v,
    input logic signed [CW-1:0] lim
  );
    logic signed [CW-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r[INTEG_WIDTH-1:0];
  endfunction

  // Configuration and integrator state
  logic signed [GW-1:0]          kpp_q, kip_q, kpv_q, kiv_q;
  logic [LW-1:0]                 limit_q;
  logic signed [INTEG_WIDTH-1:0] pint_q, pint_d, vint_q, vint_d;
  logic                          out_valid_q, out_valid_d;

  // Working registers
  logic signed [DATA_WIDTH-1:0]  perr_q, perr_d, spd_q, serr_q, serr_d;
  logic signed [DATA_WIDTH-1:0]  out_value_q, out_value_d;
  logic                          flag_q, flag_d, out_sat_q;
  logic signed [PW-1:0]          prod_q, prod_d, acc_q;

  // Combinational helpers
  logic signed [GW-1:0]          mul_a;
  logic signed [BW-1:0]          mul_b;
  logic signed [SW-1:0]          sum_w, shift_w, perr_w, serr_w;
  logic signed [DATA_WIDTH-1:0]  cp_w, drv_w;
  logic signed [CW-1:0]          lim_w;
  logic [CW-1:0]                 lim_cfg_w, lim_top_w;

  // Effective clamp magnitude
  assign lim_cfg_w = CW'(limit_q);
  assign lim_top_w = CW'(ITOP);
  assign lim_w     = (lim_cfg_w < lim_top_w) ? $signed(lim_cfg_w) : $signed(lim_top_w);

  // Select multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      cpv_pkg::MUL_POS_PROP: begin
        mul_a = kpp_q;
        mul_b = BW'(perr_q);
      end
      cpv_pkg::MUL_POS_INTEG: begin
        mul_a = kip_q;
        mul_b = BW'(pint_q);
      end
      cpv_pkg::MUL_VEL_PROP: begin
        mul_a = kpv_q;
        mul_b = BW'(serr_q);
      end
      cpv_pkg::MUL_VEL_INTEG: begin
        mul_a = kiv_q;
        mul_b = BW'(vint_q);
      end
      default: begin
        mul_a = kpp_q;
        mul_b = BW'(perr_q);
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // Sum the two gain products and drop the fraction bits (floor)
  assign sum_w   = SW'(acc_q) + SW'(prod_q);
  assign shift_w = sum_w >>> GAIN_FRAC_BITS;

  // Position error, velocity command, speed error, drive value
  assign perr_w = SW'(ref_position_i) - SW'(meas_position_i);
  assign perr_d = sat_data(perr_w);
  assign cp_w   = sat_data(shift_w);
  assign serr_w = SW'(cp_w) - SW'(spd_q);
  assign serr_d = sat_data(serr_w);
  assign drv_w  = sat_data(shift_w);

  // Saturation flag and output register contents
  always_comb begin
    flag_d      = flag_q;
    out_value_d = out_value_q;
    if (cmd_i.load) begin
      flag_d = clipped(perr_w);
    end else if (cmd_i.cmd_step) begin
      flag_d = flag_q | clipped(shift_w) | clipped(serr_w);
    end
    if (cmd_i.out_load) begin
      out_value_d = drv_w;
    end
  end

  // Integrator steps, one per item each
  always_comb begin
    pint_d = pint_q;
    vint_d = vint_q;
    if (cmd_i.cmd_step) begin
      pint_d = clamp_integ(CW'(pint_q) + CW'(perr_q), lim_w);
    end
    if (cmd_i.out_load) begin
      vint_d = clamp_integ(CW'(vint_q) + CW'(serr_q), lim_w);
    end
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign status_o.out_stall = out_valid_q & ~out_ready_i;

  // Registers with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kpp_q       <= GAIN_ONE;
      kip_q       <= GAIN_ONE;
      kpv_q       <= GAIN_ONE;
      kiv_q       <= GAIN_ONE;
      limit_q     <= {LW{1'b1}};
      pint_q      <= '0;
      vint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pint_q      <= pint_d;
      vint_q      <= vint_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cpv_pkg::REG_GAIN_POS_PROP:  kpp_q   <= cfg_wdata_i[GW-1:0];
          cpv_pkg::REG_GAIN_POS_INTEG: kip_q   <= cfg_wdata_i[GW-1:0];
          cpv_pkg::REG_GAIN_VEL_PROP:  kpv_q   <= cfg_wdata_i[GW-1:0];
          cpv_pkg::REG_GAIN_VEL_INTEG: kiv_q   <= cfg_wdata_i[GW-1:0];
          cpv_pkg::REG_INTEG_LIMIT:    limit_q <= cfg_wdata_i[LW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    flag_q      <= flag_d;
    out_value_q <= out_value_d;
    if (cmd_i.load) begin
      perr_q <= perr_d;
      spd_q  <= meas_speed_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      acc_q  <= prod_q;
    end
    if (cmd_i.cmd_step) begin
      serr_q <= serr_d;
    end
    if (cmd_i.out_load) begin
      out_sat_q <= flag_q | clipped(shift_w);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_value_o     = out_value_q;
  assign drive_saturated_o = out_sat_q;

endmodule

// ===== rtl/core/cascaded_position_velocity_pi_unit.sv =====
// Channel   | Signals                                         | Direction
// ----------+-------------------------------------------------+----------
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i                | in
// input     | in_valid_i/in_ready_o, ref_position_i,          | in
//           | meas_position_i, meas_speed_i                   |
// result    | out_valid_o/out_ready_i, drive_value_o,         | out
//           | drive_saturated_o                               |
//
// An accepted item passes the position products, the velocity command, the
// velocity products and a finish step into the output register; the single shared
// 16 x 24 multiplier forms the four gain products in turn, one item at a time.
// Reset restores the default gains (1.0), the full clamp limit and zero integrals.
// A result not taken holds the sequencer in its last step; the next item waits.
// Top level: sequencer and datapath. Depends on cpv_pkg, cpv_ctrl, cpv_datapath.
module cascaded_position_velocity_pi_unit #(
  parameter int unsigned DATA_WIDTH     = 16,
  parameter int unsigned INTEG_WIDTH    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]   ref_position_i,
  input  logic signed [DATA_WIDTH-1:0]   meas_position_i,
  input  logic signed [DATA_WIDTH-1:0]   meas_speed_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [DATA_WIDTH-1:0]   drive_value_o,
  output logic                           drive_saturated_o
);

  cpv_pkg::cmd_t    cmd;
  cpv_pkg::status_t status;

  // Sequencer
  cpv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and state
  cpv_datapath #(
    .DATA_WIDTH     (DATA_WIDTH),
    .INTEG_WIDTH    (INTEG_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .ref_position_i    (ref_position_i),
    .meas_position_i   (meas_position_i),
    .meas_speed_i      (meas_speed_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_value_o     (drive_value_o),
    .drive_saturated_o (drive_saturated_o)
  );

endmodule

// ===== rtl/core/cpv_checker.sv =====
// Port-level checks for the cascaded PI unit, bound to its top level.
// Depends on cascaded_position_velocity_pi_unit.
module cpv_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] drive_value_o,
  input logic                  drive_saturated_o
);

  // One item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // A fresh result is set as the sequencer leaves its finish step, so each rise
  // must go back to an accepted item
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 7))
    else $error("result without a matching item");

  // Hold a result that is not taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(drive_value_o) && $stable(drive_saturated_o)))
    else $error("result dropped or changed under stall");

endmodule

bind cascaded_position_velocity_pi_unit cpv_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_cpv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .drive_value_o     (drive_value_o),
  .drive_saturated_o (drive_saturated_o)
);

// ===== tb/sv/cpv_drive_checker.sv =====
// Checker for the cascaded position/velocity PI unit: watches config writes and both
// item channels, predicts each drive item and compares it with what the unit emits.
// Depends on cpv_pkg.
`timescale 1ns / 100ps

module cpv_drive_checker #(
  parameter int unsigned DATA_W    = 16,
  parameter int unsigned INTEG_W   = 24,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cpv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cpv_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [DATA_W-1:0]          ref_position_i,
  input  logic signed [DATA_W-1:0]          meas_position_i,
  input  logic signed [DATA_W-1:0]          meas_speed_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [DATA_W-1:0]          drive_value_i,
  input  logic                              drive_saturated_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  localparam longint DATA_MAX  = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint DATA_MIN  = -DATA_MAX - 1;
  localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     saturated;
  } drive_item_t;

  // Shadow of the unit's registers and integrators
  logic signed [cpv_pkg::GAIN_W-1:0] gain_pp, gain_pi, gain_vp, gain_vi;
  logic [cpv_pkg::LIMIT_W-1:0]       clamp_limit;
  longint                            pos_integ, vel_integ;
  drive_item_t                       drive_want_q[$];

  function automatic longint clip_data(input longint v, inout bit clipped);
    if (v > DATA_MAX) begin
      clipped = 1'b1;
      return DATA_MAX;
    end
    if (v < DATA_MIN) begin
      clipped = 1'b1;
      return DATA_MIN;
    end
    return v;
  endfunction

  function automatic longint clamp_integral(input longint v);
    longint lim;
    lim = (longint'(clamp_limit) < INTEG_MAX) ? longint'(clamp_limit) : INTEG_MAX;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Form one drive item, then step both integrators (forward Euler)
  function automatic drive_item_t predict_drive(input logic signed [DATA_W-1:0] ref_pos,
                                                input logic signed [DATA_W-1:0] meas_pos,
                                                input logic signed [DATA_W-1:0] meas_spd);
    drive_item_t res;
    bit          clipped;
    longint      pos_err, vel_cmd, spd_err, drv;
    clipped = 1'b0;
    pos_err = clip_data(longint'(ref_pos) - longint'(meas_pos), clipped);
    // arithmetic shift of a signed sum rounds toward minus infinity
    vel_cmd = clip_data((longint'(gain_pp) * pos_err + longint'(gain_pi) * pos_integ)
                        >>> FRAC_BITS, clipped);
    spd_err = clip_data(vel_cmd - longint'(meas_spd), clipped);
    drv     = clip_data((longint'(gain_vp) * spd_err + longint'(gain_vi) * vel_integ)
                        >>> FRAC_BITS, clipped);
    pos_integ = clamp_integral(pos_integ + pos_err);
    vel_integ = clamp_integral(vel_integ + spd_err);
    res.value     = drv[DATA_W-1:0];
    res.saturated = clipped;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_item_t want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      gain_pp      = 16'sd256;
      gain_pi      = 16'sd256;
      gain_vp      = 16'sd256;
      gain_vi      = 16'sd256;
      clamp_limit  = '1;
      pos_integ    = 0;
      vel_integ    = 0;
      drive_want_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // track register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cpv_pkg::REG_GAIN_POS_PROP:  gain_pp = cfg_wdata_i[cpv_pkg::GAIN_W-1:0];
          cpv_pkg::REG_GAIN_POS_INTEG: gain_pi = cfg_wdata_i[cpv_pkg::GAIN_W-1:0];
          cpv_pkg::REG_GAIN_VEL_PROP:  gain_vp = cfg_wdata_i[cpv_pkg::GAIN_W-1:0];
          cpv_pkg::REG_GAIN_VEL_INTEG: gain_vi = cfg_wdata_i[cpv_pkg::GAIN_W-1:0];
          cpv_pkg::REG_INTEG_LIMIT:    clamp_limit = cfg_wdata_i[cpv_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      // compare an emitted item with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (drive_want_q.size() == 0) begin
          $error("drive item with no prediction pending: value %0d saturated %0b",
                 drive_value_i, drive_saturated_i);
          errs++;
        end else begin
          want = drive_want_q.pop_front();
          if (drive_value_i !== want.value) begin
            $error("drive_value: expected %0d, got %0d", want.value, drive_value_i);
            errs++;
          end
          if (drive_saturated_i !== want.saturated) begin
            $error("drive_saturated: expected %0b, got %0b", want.saturated,
                   drive_saturated_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      // predict for each accepted input item
      if (in_valid_i && in_ready_i)
        drive_want_q.push_back(predict_drive(ref_position_i, meas_position_i, meas_speed_i));
      pending_o <= drive_want_q.size();
    end
  end

endmodule

// ===== tb/sv/cascaded_position_velocity_pi_unit_test.sv =====
// Testbench top for the cascaded position/velocity PI unit: clock, reset, register
// writes, input items and result back-pressure, with the verdict at the end.
// Depends on cpv_pkg, cpv_drive_checker and the unit itself.
`timescale 1ns / 100ps

module cascaded_position_velocity_pi_unit_test;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned CFG_W      = cpv_pkg::CFG_DATA_W;
  localparam int unsigned PHASES     = 9;
  localparam int unsigned PHASE_LEN  = 103;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [cpv_pkg::CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]                  cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [DATA_W-1:0]          ref_position_i;
  logic signed [DATA_W-1:0]          meas_position_i;
  logic signed [DATA_W-1:0]          meas_speed_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [DATA_W-1:0]          drive_value_o;
  logic                              drive_saturated_o;
  int unsigned                       fail_count;
  int unsigned                       pending;

  bit          calm;
  int          track_ref, track_meas, prev_meas;
  int unsigned idle_cycles;
  int unsigned stall_left;

  always #5 clk_i = ~clk_i;

  cascaded_position_velocity_pi_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .ref_position_i    (ref_position_i),
    .meas_position_i   (meas_position_i),
    .meas_speed_i      (meas_speed_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_value_o     (drive_value_o),
    .drive_saturated_o (drive_saturated_o)
  );

  cpv_drive_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .ref_position_i    (ref_position_i),
    .meas_position_i   (meas_position_i),
    .meas_speed_i      (meas_speed_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_value_i     (drive_value_o),
    .drive_saturated_i (drive_saturated_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Result side: stall in random bursts, never once calm
  initial begin
    out_ready_i = 1'b1;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL cascaded_position_velocity_pi_unit");
      $finish;
    end
  end

  // Write one register; entered and left at a falling edge
  task automatic write_reg(input logic [cpv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every predicted item has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Drain, then let the unit settle before touching its registers
  task automatic settle();
    drain();
    repeat (10) @(negedge clk_i);
  endtask

  // Offer one item and hold it until accepted
  task automatic push_item(input logic signed [DATA_W-1:0] rp,
                           input logic signed [DATA_W-1:0] mp,
                           input logic signed [DATA_W-1:0] sp);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    ref_position_i  <= rp;
    meas_position_i <= mp;
    meas_speed_i    <= sp;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sh7fff;
    endcase
  endfunction

  // Mostly a lagging tracking trajectory, with noise and corner values mixed in
  task automatic next_item(output logic signed [DATA_W-1:0] rp,
                           output logic signed [DATA_W-1:0] mp,
                           output logic signed [DATA_W-1:0] sp);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      track_ref += int'($urandom_range(0, 400)) - 200;
      if (track_ref > 30000) track_ref = 30000;
      if (track_ref < -30000) track_ref = -30000;
      prev_meas   = track_meas;
      track_meas += (track_ref - track_meas) / 4 + int'($urandom_range(0, 16)) - 8;
      rp = DATA_W'(track_ref);
      mp = DATA_W'(track_meas);
      sp = DATA_W'(track_meas - prev_meas);
    end else if (pick < 9) begin
      rp = DATA_W'($urandom);
      mp = DATA_W'($urandom);
      sp = DATA_W'($urandom);
    end else begin
      rp = corner_value();
      mp = corner_value();
      sp = corner_value();
    end
  endtask

  // Gain word: low bits carry the gain, upper bits are junk the unit ignores
  function automatic logic [CFG_W-1:0] pick_gain_word();
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom);
    case ($urandom_range(0, 6))
      0:       w[cpv_pkg::GAIN_W-1:0] = 16'sd256;
      1:       w[cpv_pkg::GAIN_W-1:0] = 16'(int'($urandom_range(0, 2048)) - 1024);
      2:       w[cpv_pkg::GAIN_W-1:0] = 16'sh8000;
      3:       w[cpv_pkg::GAIN_W-1:0] = 16'sh7fff;
      4:       w[cpv_pkg::GAIN_W-1:0] = 16'($urandom_range(0, 255));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] pick_limit_word();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_W'($urandom_range(1, 1000));
      2:       return '1;
      3:       return CFG_W'($urandom_range(1000, 100000));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic signed [DATA_W-1:0] rp, mp, sp;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    ref_position_i  = '0;
    meas_position_i = '0;
    meas_speed_i    = '0;
    rst_ni          = 1'b0;
    calm            = 1'b0;
    idle_cycles     = 0;
    track_ref       = 0;
    track_meas      = 0;
    prev_meas       = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset gains: zero, clipped position errors, speed extremes
    push_item(16'sd0, 16'sd0, 16'sd0);
    push_item(16'sh7fff, 16'sh8000, 16'sd0);
    push_item(16'sh8000, 16'sh7fff, 16'sd0);
    push_item(16'sd0, 16'sd0, 16'sh7fff);
    push_item(16'sd0, 16'sd0, 16'sh8000);
    push_item(16'sh7fff, 16'sh7fff, 16'sh8000);
    push_item(-16'sd1, 16'sd0, 16'sd0);
    push_item(16'sd1, 16'sd0, 16'sd0);

    // Half gains, no integral: negative products must round down
    settle();
    write_reg(cpv_pkg::REG_GAIN_POS_PROP, 23'd128);
    write_reg(cpv_pkg::REG_GAIN_POS_INTEG, 23'd0);
    write_reg(cpv_pkg::REG_GAIN_VEL_PROP, 23'd128);
    write_reg(cpv_pkg::REG_GAIN_VEL_INTEG, 23'd0);
    write_reg(cpv_pkg::REG_INTEG_LIMIT + 3'd1, CFG_W'($urandom));
    push_item(-16'sd1, 16'sd0, 16'sd0);
    push_item(-16'sd3, 16'sd0, 16'sd0);
    push_item(16'sd3, 16'sd0, 16'sd0);

    // Small clamp limit: integrators pinned at the limit
    settle();
    write_reg(cpv_pkg::REG_GAIN_POS_INTEG, 23'd256);
    write_reg(cpv_pkg::REG_GAIN_VEL_INTEG, 23'd256);
    write_reg(cpv_pkg::REG_INTEG_LIMIT, 23'd5);
    repeat (4) push_item(16'sd100, 16'sd0, 16'sd0);

    // Zero limit: integrators held at zero
    settle();
    write_reg(cpv_pkg::REG_INTEG_LIMIT, 23'd0);
    repeat (3) push_item(16'sd50, 16'sd0, 16'sd10);

    // Extreme gains with full limit
    settle();
    write_reg(cpv_pkg::REG_GAIN_POS_PROP, 23'h7f8000);
    write_reg(cpv_pkg::REG_GAIN_POS_INTEG, 23'h007fff);
    write_reg(cpv_pkg::REG_GAIN_VEL_PROP, 23'h007fff);
    write_reg(cpv_pkg::REG_GAIN_VEL_INTEG, 23'h008000);
    write_reg(cpv_pkg::REG_INTEG_LIMIT, '1);
    push_item(16'sd1000, -16'sd1000, 16'sd500);
    push_item(16'sh8000, 16'sh7fff, 16'sh7fff);

    // Random phases, each with its own register setting; the last one runs calm
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      calm = (phase == PHASES - 1);
      write_reg(cpv_pkg::REG_GAIN_POS_PROP, pick_gain_word());
      write_reg(cpv_pkg::REG_GAIN_POS_INTEG, pick_gain_word());
      write_reg(cpv_pkg::REG_GAIN_VEL_PROP, pick_gain_word());
      write_reg(cpv_pkg::REG_GAIN_VEL_INTEG, pick_gain_word());
      write_reg(cpv_pkg::REG_INTEG_LIMIT, pick_limit_word());
      if ($urandom_range(0, 2) == 0)
        write_reg(cpv_pkg::REG_INTEG_LIMIT + 3'($urandom_range(1, 3)), CFG_W'($urandom));
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n == PHASE_LEN / 2)
          drain();
        next_item(rp, mp, sp);
        push_item(rp, mp, sp);
      end
    end

    // Wait out the last results, then a margin for anything stray
    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS cascaded_position_velocity_pi_unit");
    end else begin
      $display("FAIL cascaded_position_velocity_pi_unit");
    end
    $finish;
  end

endmodule
